FILE: rtl/core/torf_pkg.sv
// torf_pkg: shared types and byte codes for the telnet option refusal filter
// used by torf_decode and telnet_option_refusal_filter; no dependencies
package torf_pkg;

  localparam logic [7:0] BYTE_IAC  = 8'd255;
  localparam logic [7:0] BYTE_DONT = 8'd254;
  localparam logic [7:0] BYTE_DO   = 8'd253;
  localparam logic [7:0] BYTE_WONT = 8'd252;
  localparam logic [7:0] BYTE_WILL = 8'd251;
  localparam logic [7:0] BYTE_SB   = 8'd250;
  localparam logic [7:0] BYTE_SE   = 8'd240;
  localparam logic [7:0] BYTE_CR   = 8'd13;
  localparam logic [7:0] BYTE_LF   = 8'd10;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic VERB_WONT = 1'b0;
  localparam logic VERB_DONT = 1'b1;

  localparam int unsigned OutTdataW = 24;

  typedef enum logic [2:0] {
    ST_DATA     = 3'd0,
    ST_AFTER_CR = 3'd1,
    ST_CMD      = 3'd2,
    ST_OPTION   = 3'd3,
    ST_SUBNEG   = 3'd4,
    ST_SUB_IAC  = 3'd5
  } parse_state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       reply_verb;
    logic [7:0] option_code;
  } torf_result_t;

endpackage

FILE: rtl/core/torf_decode.sv
// torf_decode: combinational parse step for one received byte
// depends on torf_pkg
module torf_decode (
  input  torf_pkg::parse_state_e state_i,
  input  logic                   dont_i,
  input  logic [7:0]             byte_i,
  output torf_pkg::parse_state_e state_o,
  output logic                   dont_o,
  output logic                   res_valid_o,
  output torf_pkg::torf_result_t res_o
);
  import torf_pkg::*;

  always_comb begin
    state_o     = ST_DATA;
    dont_o      = dont_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (state_i)
      ST_AFTER_CR: begin
        state_o = ST_DATA;
      end
      ST_CMD: begin
        if (byte_i == BYTE_DO || byte_i == BYTE_DONT) begin
          dont_o  = VERB_WONT;
          state_o = ST_OPTION;
        end else if (byte_i == BYTE_WILL || byte_i == BYTE_WONT) begin
          dont_o  = VERB_DONT;
          state_o = ST_OPTION;
        end else if (byte_i == BYTE_SB) begin
          state_o = ST_SUBNEG;
        end else begin
          state_o = ST_DATA;
        end
      end
      ST_OPTION: begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_REPLY;
        res_o.reply_verb  = dont_i;
        res_o.option_code = byte_i;
        state_o           = ST_DATA;
      end
      ST_SUBNEG: begin
        state_o = (byte_i == BYTE_IAC) ? ST_SUB_IAC : ST_SUBNEG;
      end
      ST_SUB_IAC: begin
        state_o = (byte_i == BYTE_SE) ? ST_DATA : ST_SUBNEG;
      end
      default: begin
        if (byte_i == BYTE_IAC) begin
          state_o = ST_CMD;
        end else if (byte_i == BYTE_CR) begin
          state_o         = ST_AFTER_CR;
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = BYTE_LF;
        end else begin
          state_o         = ST_DATA;
          res_valid_o     = 1'b1;
          res_o.kind      = KIND_DATA;
          res_o.data_byte = byte_i;
        end
      end
    endcase
  end

endmodule

FILE: rtl/core/telnet_option_refusal_filter.sv
// telnet_option_refusal_filter: top level, input register, parse step, result register
// depends on torf_pkg and torf_decode
//
// usage:
//   s_axis carries one byte from the telnet peer per beat in tdata[7:0].
//   m_axis carries zero or one result per input byte. tuser is the kind:
//   0 = data byte for the shell, 1 = refusal reply for the peer.
//   a reply means send IAC WONT (reply_verb 0) or IAC DONT (reply_verb 1)
//   followed by option_code.
//   a byte accepted into the input register passes the parse step into the
//   result register and on to m_axis once the output side is free.
//   throughput: one byte per cycle while the receiver is ready, set by the
//   combinational parse step between the input register and the result register.
//   a command split over any number of beats is parsed across them.
//   reset puts the parser in the normal data state with both registers empty.
//   when the receiver stalls the result holds in the result register and one
//   more byte is taken into the input register; then s_axis_tready_o drops.
module telnet_option_refusal_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // rx_byte[7:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // data_byte[7:0], reply_verb[8], option_code[16:9]
  output logic        m_axis_tuser_o    // kind[0]
);
  import torf_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  parse_state_e state_q, state_d;
  logic         dont_q, dont_d;
  logic         out_valid_q;
  torf_result_t out_q;
  logic         res_valid;
  torf_result_t res;
  logic         advance;
  logic         in_take;

  torf_decode u_decode (
    .state_i     (state_q),
    .dont_i      (dont_q),
    .byte_i      (in_byte_q),
    .state_o     (state_d),
    .dont_o      (dont_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= ST_DATA;
      dont_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q <= state_d;
        dont_q  <= dont_d;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {7'd0, out_q.option_code, out_q.reply_verb, out_q.data_byte};

endmodule

FILE: tb/sv/tb_telnet_option_refusal_filter.sv
// tb_telnet_option_refusal_filter: self-checking bench for the telnet option refusal filter
// directed byte sequences, then random telnet traffic with bursty input and stalled output
// depends on torf_pkg and telnet_option_refusal_filter
module tb_telnet_option_refusal_filter;
  import torf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 1100;
  localparam int unsigned MaxPrints = 30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  parse_state_e  parser_state = ST_DATA;
  logic          pending_verb = VERB_WONT;
  torf_result_t  awaited_out[$];

  int unsigned bytes_sent = 0;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  bit          sender_gaps = 1'b0;

  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_cnt = 0;

  telnet_option_refusal_filter uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1ms;
    $display("simulation failed");
    $finish;
  end

  // receiver stall pattern: always ready, coin flip, or ready only when stall_cnt is a multiple of four
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(8, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    stall_cnt <= stall_cnt + 1;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      default: m_axis_tready <= (stall_cnt % 4 == 0);
    endcase
  end

  function automatic void filter_byte(input logic [7:0] rx);
    torf_result_t res;
    bit           emit;
    res = '0;
    emit = 1'b0;
    case (parser_state)
      ST_AFTER_CR: parser_state = ST_DATA;
      ST_CMD: begin
        if (rx == BYTE_DO || rx == BYTE_DONT) begin
          pending_verb = VERB_WONT;
          parser_state = ST_OPTION;
        end else if (rx == BYTE_WILL || rx == BYTE_WONT) begin
          pending_verb = VERB_DONT;
          parser_state = ST_OPTION;
        end else if (rx == BYTE_SB) begin
          parser_state = ST_SUBNEG;
        end else begin
          parser_state = ST_DATA;
        end
      end
      ST_OPTION: begin
        res.kind = KIND_REPLY;
        res.reply_verb = pending_verb;
        res.option_code = rx;
        emit = 1'b1;
        parser_state = ST_DATA;
      end
      ST_SUBNEG: begin
        if (rx == BYTE_IAC) parser_state = ST_SUB_IAC;
      end
      ST_SUB_IAC: parser_state = (rx == BYTE_SE) ? ST_DATA : ST_SUBNEG;
      default: begin
        if (rx == BYTE_IAC) begin
          parser_state = ST_CMD;
        end else if (rx == BYTE_CR) begin
          parser_state = ST_AFTER_CR;
          res.kind = KIND_DATA;
          res.data_byte = BYTE_LF;
          emit = 1'b1;
        end else begin
          parser_state = ST_DATA;
          res.kind = KIND_DATA;
          res.data_byte = rx;
          emit = 1'b1;
        end
      end
    endcase
    if (emit) awaited_out.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [23:0] got,
                                 input logic [23:0] want);
    mismatches++;
    if (mismatches <= MaxPrints)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
  endtask

  // output checker: sample before the edge, judge at the edge
  initial begin
    logic         take;
    logic [23:0]  beat_data;
    logic         beat_kind;
    torf_result_t want;
    forever begin
      @(negedge clk_i);
      take = m_axis_tvalid && m_axis_tready;
      beat_data = m_axis_tdata;
      beat_kind = m_axis_tuser;
      @(posedge clk_i);
      if (take) begin
        if (awaited_out.size() == 0) begin
          report_mismatch("unexpected beat", beat_data, '0);
        end else begin
          want = awaited_out.pop_front();
          if (beat_kind !== want.kind)
            report_mismatch("kind", 24'(beat_kind), 24'(want.kind));
          if (beat_data[7:0] !== want.data_byte)
            report_mismatch("data_byte", 24'(beat_data[7:0]), 24'(want.data_byte));
          if (beat_data[8] !== want.reply_verb)
            report_mismatch("reply_verb", 24'(beat_data[8]), 24'(want.reply_verb));
          if (beat_data[16:9] !== want.option_code)
            report_mismatch("option_code", 24'(beat_data[16:9]), 24'(want.option_code));
          if (beat_data[23:17] !== '0)
            report_mismatch("tdata pad", 24'(beat_data[23:17]), '0);
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] rx);
    logic rdy;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= rx;
    forever begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      if (rdy) filter_byte(rx);
      @(posedge clk_i);
      if (rdy) break;
    end
    bytes_sent++;
    if (sender_gaps) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (awaited_out.size() != 0);
  endtask

  task automatic test_plain_data();
    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(BYTE_DONT);
  endtask

  task automatic test_carriage_return();
    send_byte(BYTE_CR);
    send_byte(BYTE_IAC);
    send_byte(BYTE_CR);
    send_byte(BYTE_CR);
  endtask

  task automatic test_option_refusal();
    send_byte(BYTE_IAC);
    send_byte(BYTE_DO);
    send_byte(8'h01);
    send_byte(BYTE_IAC);
    send_byte(BYTE_DONT);
    send_byte(8'hff);
    send_byte(BYTE_IAC);
    send_byte(BYTE_WILL);
    send_byte(8'h00);
    send_byte(BYTE_IAC);
    send_byte(BYTE_WONT);
    send_byte(8'h80);
  endtask

  task automatic test_subnegotiation();
    send_byte(BYTE_IAC);
    send_byte(BYTE_SB);
    send_byte(BYTE_IAC);
    send_byte(BYTE_IAC);
    send_byte(BYTE_SE);
    send_byte(BYTE_IAC);
    send_byte(BYTE_SE);
  endtask

  task automatic test_other_commands();
    send_byte(BYTE_IAC);
    send_byte(BYTE_IAC);
    send_byte(BYTE_IAC);
    send_byte(8'hf1);
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned body;
    logic [7:0]  rx;
    bit          drained;
    drained = 1'b0;
    while (bytes_sent < RandomBytes + 31) begin
      if ($urandom_range(0, 39) == 0) sender_gaps = !sender_gaps;
      if (!drained && bytes_sent > RandomBytes / 2) begin
        wait_all_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        send_byte(8'($urandom_range(0, 254)));
      end else if (pick < 45) begin
        send_byte(BYTE_CR);
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        send_byte(BYTE_IAC);
        case ($urandom_range(0, 3))
          0: send_byte(BYTE_DO);
          1: send_byte(BYTE_DONT);
          2: send_byte(BYTE_WILL);
          default: send_byte(BYTE_WONT);
        endcase
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick < 80) begin
        send_byte(BYTE_IAC);
        send_byte(BYTE_SB);
        body = $urandom_range(0, 6);
        repeat (body) begin
          if ($urandom_range(0, 5) == 0) begin
            send_byte(BYTE_IAC);
            send_byte(BYTE_IAC);
          end else begin
            send_byte(8'($urandom_range(0, 254)));
          end
        end
        send_byte(BYTE_IAC);
        send_byte(BYTE_SE);
      end else if (pick < 88) begin
        rx = 8'($urandom_range(0, 255));
        if (rx == BYTE_DO || rx == BYTE_DONT || rx == BYTE_WILL || rx == BYTE_WONT ||
            rx == BYTE_SB)
          rx = BYTE_IAC;
        send_byte(BYTE_IAC);
        send_byte(rx);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_data();
    test_carriage_return();
    test_option_refusal();
    test_subnegotiation();
    test_other_commands();
    wait_all_results();
    sender_gaps = 1'b1;
    test_random_traffic();
    wait_all_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && awaited_out.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/torf_pkg.sv
rtl/core/torf_decode.sv
rtl/core/telnet_option_refusal_filter.sv
tb/sv/tb_telnet_option_refusal_filter.sv
